// ===== hw/rtl/alidf_pkg.sv =====
// ----------------------------------------------------------------------------
// alidf_pkg
// Shared types and codes for the array list block: operation and status
// codes, controller states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package alidf_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutPosW = 8;
  localparam int unsigned OutLenW = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_POS   = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic exec;      // apply the operation to the cell row
    logic load_out;  // build the result into the output register
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/alidf_ctrl.sv =====
// ----------------------------------------------------------------------------
// alidf_ctrl
// Sequencer for the array list: accepts a request, runs the execute step,
// then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module alidf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output alidf_pkg::ctrl_cmd_t cmd_o
);

  alidf_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alidf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == alidf_pkg::ST_IDLE) ||
                 ((state_q == alidf_pkg::ST_DONE) && out_free);
    accept     = in_valid_i && in_ready_o;

    cmd_o          = '0;
    cmd_o.load_req = accept;
    state_d        = state_q;

    unique case (state_q)
      alidf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = alidf_pkg::ST_EXEC;
        end
      end
      alidf_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = alidf_pkg::ST_DONE;
      end
      alidf_pkg::ST_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = accept ? alidf_pkg::ST_EXEC : alidf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = alidf_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/alidf_dp.sv =====
// ----------------------------------------------------------------------------
// alidf_dp
// Datapath of the array list: request registers, a row of element cells
// that shift up or down in one step, parallel match compare with a
// registered match vector, and the output register.
// ----------------------------------------------------------------------------
module alidf_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  alidf_pkg::ctrl_cmd_t                  cmd_i,
  input  logic [alidf_pkg::FuncW-1:0]           func_i,
  input  logic [alidf_pkg::PosW-1:0]            position_i,
  input  logic signed [alidf_pkg::ValueW-1:0]   value_i,
  output logic [alidf_pkg::StatusW-1:0]         status_o,
  output logic [alidf_pkg::OutPosW-1:0]         found_position_o,
  output logic [alidf_pkg::OutLenW-1:0]         length_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((LenW > alidf_pkg::PosW) ? LenW : alidf_pkg::PosW) + 1;

  // request
  alidf_pkg::func_e                  func_q;
  logic [alidf_pkg::PosW-1:0]        pos_q;
  logic signed [alidf_pkg::ValueW-1:0] value_q;

  // list state
  logic signed [alidf_pkg::ValueW-1:0] cells_q [CAPACITY];
  logic signed [alidf_pkg::ValueW-1:0] cells_d [CAPACITY];
  logic [LenW-1:0]                   len_q, len_d;

  // execute results
  logic [CAPACITY-1:0]               match_q, match_d;
  alidf_pkg::status_e                st_q, st_d;
  logic                              shift_up, shift_down;

  // output register
  alidf_pkg::status_e                out_status_q;
  logic [alidf_pkg::OutPosW-1:0]     out_pos_q;
  logic [alidf_pkg::OutLenW-1:0]     out_len_q;

  logic [CmpW-1:0]                   pos_c, len_c;
  logic                              full, ins_bad, del_bad;
  logic [IdxW-1:0]                   first_idx;
  logic                              any_match;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q  <= alidf_pkg::func_e'(func_i);
      pos_q   <= position_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    pos_c   = CmpW'(pos_q);
    len_c   = CmpW'(len_q);
    full    = (len_q == LenW'(CAPACITY));
    ins_bad = (pos_c == '0) || (pos_c > len_c + CmpW'(1));
    del_bad = (pos_c == '0) || (pos_c > len_c);

    st_d       = alidf_pkg::STATUS_OK;
    len_d      = len_q;
    shift_up   = 1'b0;
    shift_down = 1'b0;

    unique case (func_q)
      alidf_pkg::FUNC_FIND: begin
        st_d = alidf_pkg::STATUS_OK;
      end
      alidf_pkg::FUNC_INSERT: begin
        if (full) begin
          st_d = alidf_pkg::STATUS_FULL;
        end else if (ins_bad) begin
          st_d = alidf_pkg::STATUS_BAD_POS;
        end else begin
          shift_up = 1'b1;
          len_d    = LenW'(len_q + LenW'(1));
        end
      end
      alidf_pkg::FUNC_DELETE: begin
        if (del_bad) begin
          st_d = alidf_pkg::STATUS_BAD_POS;
        end else begin
          shift_down = 1'b1;
          len_d      = LenW'(len_q - LenW'(1));
        end
      end
      alidf_pkg::FUNC_CLEAR: begin
        len_d = '0;
      end
      default: begin
        st_d = alidf_pkg::STATUS_OK;
      end
    endcase
  end

  // one cell per entry; each looks only at its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cells_d[i] = cells_q[i];
      if (shift_up) begin
        if (CmpW'(i + 1) == pos_c) begin
          cells_d[i] = value_q;
        end else if (CmpW'(i + 1) > pos_c) begin
          if (i > 0) begin
            cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (shift_down) begin
        if ((CmpW'(i + 1) >= pos_c) && (i < CAPACITY - 1)) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
      match_d[i] = (cells_q[i] == value_q) && (CmpW'(i) < len_c);
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.exec) begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      match_q <= match_d;
      st_q    <= st_d;
    end
  end

  // lowest matching entry wins
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IdxW'(i);
      end
    end
    any_match = |match_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_len_q <= alidf_pkg::OutLenW'(len_q);
      if (func_q == alidf_pkg::FUNC_FIND) begin
        if (any_match) begin
          out_status_q <= alidf_pkg::STATUS_OK;
          out_pos_q    <= alidf_pkg::OutPosW'(LenW'(first_idx) + LenW'(1));
        end else begin
          out_status_q <= alidf_pkg::STATUS_NOT_FOUND;
          out_pos_q    <= '0;
        end
      end else begin
        out_status_q <= st_q;
        out_pos_q    <= '0;
      end
    end
  end

  assign status_o         = out_status_q;
  assign found_position_o = out_pos_q;
  assign length_o         = out_len_q;

endmodule

// ===== hw/rtl/array_list_insert_delete_find_top.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_top
// Ordered list of signed 32-bit values with find, insert, delete and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the in_* channel (func, position, value) under
//   valid/ready; each request gives exactly one result on the out_*
//   channel (status, found_position, length), in order.
//   Positions are 1-based. Insert shifts later entries up, delete shifts
//   them down; all cells move in a single step, and find compares every
//   stored entry in parallel.
//   Each request is captured, executed on the cell row, then its result
//   is loaded into the output register; the next request can be taken
//   as that result is loaded, but not during the execute step.
//   The output register holds a finished result while the receiver
//   stalls; one further request is still accepted and executed, and
//   intake stops while its result waits behind the stalled one.
//   Reset empties the list (length zero) and drops any request in flight;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module array_list_insert_delete_find_top #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [alidf_pkg::FuncW-1:0]         func_i,
  input  logic [alidf_pkg::PosW-1:0]          position_i,
  input  logic signed [alidf_pkg::ValueW-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [alidf_pkg::StatusW-1:0]       status_o,
  output logic [alidf_pkg::OutPosW-1:0]       found_position_o,
  output logic [alidf_pkg::OutLenW-1:0]       length_o
);

  alidf_pkg::ctrl_cmd_t cmd;

  alidf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  alidf_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (func_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .length_o         (length_o)
  );

endmodule

// ===== tb/sv/array_list_insert_delete_find_top_tb.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_top_tb
// Self-checking bench for the array list block. A behavioral list model
// predicts status, found position and length for every accepted request.
// Directed cases hit the edges of position and value. A fill pass drives
// the list to capacity and back to empty. Random traffic, with idle gaps
// on both channels and one long receiver hold-off, exercises the rest.
// ----------------------------------------------------------------------------
module array_list_insert_delete_find_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 128;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    alidf_pkg::status_e status;
    logic [7:0]         found_pos;
    logic [7:0]         length;
  } list_result_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [alidf_pkg::FuncW-1:0]          func_i;
  logic [alidf_pkg::PosW-1:0]           position_i;
  logic signed [alidf_pkg::ValueW-1:0]  value_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [alidf_pkg::StatusW-1:0]        status_o;
  logic [alidf_pkg::OutPosW-1:0]        found_position_o;
  logic [alidf_pkg::OutLenW-1:0]        length_o;

  // list model state
  logic signed [31:0] list_mem [CAPACITY];
  int                 list_len;
  int                 peak_len;

  list_result_t pending_results[$];
  list_result_t oldest_result;

  int unsigned cycle_count;
  int          fail_count;
  int          result_count;
  int          func_hits   [4];
  int          status_hits [4];
  bit          gaps_on;
  int          holdoff_left;
  int          stall_left;

  array_list_insert_delete_find_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .length_o        (length_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one request to the list model and return what the block must report.
  function automatic list_result_t list_outcome(alidf_pkg::func_e f, logic [7:0] pos,
                                                logic signed [31:0] val);
    list_result_t r;
    int           p;
    bit           hit;
    r.status    = alidf_pkg::STATUS_OK;
    r.found_pos = 8'd0;
    p           = int'(pos);
    hit         = 1'b0;
    case (f)
      alidf_pkg::FUNC_FIND: begin
        for (int i = 0; i < list_len && !hit; i++) begin
          if (list_mem[i] == val) begin
            hit         = 1'b1;
            r.found_pos = 8'(i + 1);
          end
        end
        if (!hit) r.status = alidf_pkg::STATUS_NOT_FOUND;
      end
      alidf_pkg::FUNC_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = alidf_pkg::STATUS_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = alidf_pkg::STATUS_BAD_POS;
        end else begin
          for (int i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      alidf_pkg::FUNC_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = alidf_pkg::STATUS_BAD_POS;
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: list_len = 0;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    r.length = 8'(list_len);
    func_hits[int'(f)]++;
    status_hits[int'(r.status)]++;
    return r;
  endfunction

  // Offer one request and hold it until accepted; valid stays high afterwards.
  task automatic send_request(alidf_pkg::func_e f, logic [7:0] pos,
                              logic signed [31:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(list_outcome(f, pos, val));
  endtask

  // Mostly stored values when drawing from the list, so finds hit; a small pool makes duplicates.
  function automatic logic signed [31:0] pick_value(bit from_list);
    int r;
    r = $urandom_range(0, 99);
    if (from_list && list_len > 0 && r < 70) return list_mem[$urandom_range(0, list_len - 1)];
    if (r < 80) return 32'(int'($urandom_range(0, 7)) - 4);
    if (r < 85) return (r[0]) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  task automatic send_random_insert();
    logic [7:0] pos;
    if ($urandom_range(0, 99) < 85) pos = 8'($urandom_range(1, list_len + 1));
    else pos = 8'($urandom_range(0, 255));
    send_request(alidf_pkg::FUNC_INSERT, pos, pick_value(1'b0));
  endtask

  task automatic send_random_delete();
    logic [7:0] pos;
    if (list_len > 0 && $urandom_range(0, 99) < 85) pos = 8'($urandom_range(1, list_len));
    else pos = 8'($urandom_range(0, 255));
    send_request(alidf_pkg::FUNC_DELETE, pos, $urandom);
  endtask

  task automatic send_random_request();
    int r;
    int ins_share;
    r         = $urandom_range(0, 99);
    ins_share = (list_len < 40) ? 45 : 35;
    if (r < 3) begin
      send_request(alidf_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), $urandom);
    end else if (r < 30) begin
      send_request(alidf_pkg::FUNC_FIND, 8'($urandom_range(0, 255)), pick_value(1'b1));
    end else if (r < 30 + ins_share) begin
      send_random_insert();
    end else begin
      send_random_delete();
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   32'sd0);          // empty list
    send_request(alidf_pkg::FUNC_DELETE, 8'd1,   32'sd9);          // nothing to delete
    send_request(alidf_pkg::FUNC_INSERT, 8'd0,   32'sd5);          // position zero
    send_request(alidf_pkg::FUNC_INSERT, 8'd2,   32'sd5);          // past end+1
    send_request(alidf_pkg::FUNC_INSERT, 8'd1,   32'sh7fff_ffff);
    send_request(alidf_pkg::FUNC_INSERT, 8'd2,   32'sh8000_0000);  // append
    send_request(alidf_pkg::FUNC_INSERT, 8'd1,   -32'sd1);         // front
    send_request(alidf_pkg::FUNC_INSERT, 8'd2,   32'sd0);          // middle
    send_request(alidf_pkg::FUNC_INSERT, 8'd5,   -32'sd1);         // duplicate at end
    send_request(alidf_pkg::FUNC_FIND,   8'd255, -32'sd1);         // first of two matches
    send_request(alidf_pkg::FUNC_FIND,   8'd128, 32'sh8000_0000);
    send_request(alidf_pkg::FUNC_FIND,   8'd7,   32'sd12345);      // miss
    send_request(alidf_pkg::FUNC_INSERT, 8'd7,   32'sd3);          // end+2
    send_request(alidf_pkg::FUNC_INSERT, 8'd255, 32'sd3);
    send_request(alidf_pkg::FUNC_DELETE, 8'd0,   32'sd0);
    send_request(alidf_pkg::FUNC_DELETE, 8'd6,   32'sd0);          // end+1
    send_request(alidf_pkg::FUNC_DELETE, 8'd255, 32'sd0);
    send_request(alidf_pkg::FUNC_DELETE, 8'd1,   32'sd0);          // front
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   -32'sd1);         // match moved down
    send_request(alidf_pkg::FUNC_DELETE, 8'd4,   32'sd0);          // last
    send_request(alidf_pkg::FUNC_DELETE, 8'd2,   32'sd0);          // middle
    send_request(alidf_pkg::FUNC_FIND,   8'd1,   32'sh7fff_ffff);  // deleted value
    send_request(alidf_pkg::FUNC_CLEAR,  8'd170, 32'sh5555_aaaa);
    send_request(alidf_pkg::FUNC_CLEAR,  8'd85,  32'shaaaa_5555);  // clear when empty
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   32'sd0);          // stale entry must not match
  endtask

  task automatic test_fill_to_capacity();
    gaps_on = 1'b1;
    while (list_len < CAPACITY)
      send_request(alidf_pkg::FUNC_INSERT, 8'($urandom_range(1, list_len + 1)), $urandom);
    // full takes precedence over a bad position
    send_request(alidf_pkg::FUNC_INSERT, 8'd1,   $urandom);
    send_request(alidf_pkg::FUNC_INSERT, 8'd0,   $urandom);
    send_request(alidf_pkg::FUNC_INSERT, 8'd129, $urandom);
    send_request(alidf_pkg::FUNC_INSERT, 8'd255, $urandom);
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   list_mem[CAPACITY-1]);
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   list_mem[0]);
    repeat (10) send_request(alidf_pkg::FUNC_FIND, 8'd0, pick_value(1'b1));
    send_request(alidf_pkg::FUNC_DELETE, 8'd129, $urandom);
    send_request(alidf_pkg::FUNC_DELETE, 8'd128, $urandom);
    send_request(alidf_pkg::FUNC_INSERT, 8'd128, 32'sh8000_0000);
    send_request(alidf_pkg::FUNC_FIND,   8'd0,   32'sh8000_0000);
    while (list_len > 0)
      send_request(alidf_pkg::FUNC_DELETE, 8'($urandom_range(1, list_len)), $urandom);
  endtask

  // Receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    holdoff_left = HOLD_CYCLES;
    repeat (40) send_random_request();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(int count, bit with_gaps);
    gaps_on = with_gaps;
    repeat (count) send_random_request();
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls plus the hold-off requested by the tests.
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (holdoff_left > 0) begin
        out_ready_i <= 1'b0;
        holdoff_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        stall_left = draw_gap();
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: status %0d pos %0d len %0d",
                   status_o, found_position_o, length_o);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status ||
            found_position_o !== oldest_result.found_pos ||
            length_o !== oldest_result.length) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch on result %0d: exp %s pos %0d len %0d, got %0d pos %0d len %0d",
                     result_count, oldest_result.status.name(), oldest_result.found_pos,
                     oldest_result.length, status_o, found_position_o, length_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** array_list_insert_delete_find_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = alidf_pkg::FUNC_FIND;
    position_i   = '0;
    value_i      = '0;
    list_len     = 0;
    peak_len     = 0;
    cycle_count  = 0;
    fail_count   = 0;
    result_count = 0;
    holdoff_left = 0;
    gaps_on      = 1'b1;
    for (int i = 0; i < 4; i++) begin
      func_hits[i]   = 0;
      status_hits[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_capacity();
    test_backpressure();
    test_random_traffic(300, 1'b0);
    test_random_traffic(1000, 1'b1);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("requests: %0d find, %0d insert, %0d delete, %0d clear; peak length %0d",
             func_hits[alidf_pkg::FUNC_FIND], func_hits[alidf_pkg::FUNC_INSERT],
             func_hits[alidf_pkg::FUNC_DELETE], func_hits[alidf_pkg::FUNC_CLEAR], peak_len);
    $display("outcomes: %0d ok, %0d bad position, %0d full, %0d not found; %0d errors",
             status_hits[alidf_pkg::STATUS_OK], status_hits[alidf_pkg::STATUS_BAD_POS],
             status_hits[alidf_pkg::STATUS_FULL], status_hits[alidf_pkg::STATUS_NOT_FOUND],
             fail_count);
    if (fail_count == 0)
      $display("** array_list_insert_delete_find_top: PASSED **");
    else
      $display("** array_list_insert_delete_find_top: FAILED **");
    $finish;
  end

endmodule
